// ----- hdl/cht_pkg.sv -----
// Shared types and constants of the cuckoo hash table.
// Used by cht_ctrl, cht_datapath and cuckoo_hash_table; no dependencies.
`timescale 1ns / 1ps

package cht_pkg;

  // Operation codes carried in the func field
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Hash seeds and the number of remainder bits reduced per cycle
  localparam logic [63:0] HASH1_SEED = 64'd5381;
  localparam logic [63:0] HASH2_SEED = 64'd3333;
  localparam int MOD_BITS = 8;

  typedef enum logic [1:0] {
    RES_HIT1,
    RES_HIT2,
    RES_PLAIN,
    RES_DROP
  } res_kind_e;

  typedef enum logic {
    KSEL_CK,
    KSEL_RD1
  } key_sel_e;

  typedef enum logic {
    SEED_ONE,
    SEED_TWO
  } seed_sel_e;

  typedef struct packed {
    logic      load;
    logic      hash_start;
    key_sel_e  key_sel;
    seed_sel_e seed_sel;
    logic      rd1;
    logic      rd2;
    logic      wr1;
    logic      wr2;
    logic      swap;
    logic      cnt_inc;
    logic      clr;
    logic      res_load;
    res_kind_e res_kind;
  } cht_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic clr_last;
    logic is_insert;
    logic v1;
    logic eq1;
    logic v2;
    logic eq2ck;
    logic eq2ok;
    logic out_busy;
  } cht_status_t;

endpackage

// ----- hdl/cht_datapath.sv -----
// Datapath of the cuckoo hash table: hash unit, modulo unit, both tables,
// occupancy count and output register. Depends on cht_pkg.
`timescale 1ns / 1ps

module cht_datapath import cht_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cht_cmd_t    cmd_i,
  output cht_status_t status_o,
  input  logic        func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] read_value_o,
  output logic [11:0] entry_total_o,
  output logic        dropped_o,
  output logic [31:0] dropped_key_o,
  output logic [31:0] dropped_value_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int REM_W = IDX_W + 1;
  localparam int SV_W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CNT_W = $clog2(2 * TABLE_DEPTH + 1);
  localparam int MOD_STEPS = 64 / MOD_BITS;
  localparam logic [31:0] KEY_MASK = 32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [REM_W-1:0] DEPTH_R = REM_W'(TABLE_DEPTH);

  typedef struct packed {
    logic            vld;
    logic [31:0]     key;
    logic [SV_W-1:0] val;
  } entry_t;

  entry_t mem1 [TABLE_DEPTH];
  entry_t mem2 [TABLE_DEPTH];
  entry_t rd1_q, rd2_q;

  logic            func_q;
  logic [31:0]     ck_q;
  logic [SV_W-1:0] cv_q;

  logic             hashing_q, moding_q, done_q;
  logic [3:0]       step_q;
  logic [63:0]      h_q, h_fold, h_tmp;
  logic [31:0]      kb_q;
  logic             seed_two_q;
  logic [REM_W-1:0] r_q, r_tmp;
  logic [IDX_W-1:0] idx_q, clr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;

  // Fold one key byte into the running hash
  always_comb begin
    if (seed_two_q) begin
      h_fold = ((h_q << 5) - (h_q << 1) - h_q) ^ {56'd0, kb_q[7:0]};
    end else begin
      h_fold = ((h_q << 5) + h_q) ^ {56'd0, kb_q[7:0]};
    end
  end

  // Reduce MOD_BITS hash bits into the remainder, MSB first
  always_comb begin
    r_tmp = r_q;
    h_tmp = h_q;
    for (int j = 0; j < MOD_BITS; j++) begin
      r_tmp = {r_tmp[REM_W-2:0], h_tmp[63]};
      h_tmp = {h_tmp[62:0], 1'b0};
      if (r_tmp >= DEPTH_R) begin
        r_tmp = r_tmp - DEPTH_R;
      end
    end
  end

  // Sequence the hash and modulo phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hashing_q <= 1'b0;
      moding_q  <= 1'b0;
      done_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.hash_start) begin
        hashing_q <= 1'b1;
        step_q    <= '0;
      end else if (hashing_q) begin
        if (step_q == 4'(KEY_BYTES - 1)) begin
          hashing_q <= 1'b0;
          moding_q  <= 1'b1;
          step_q    <= '0;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end else if (moding_q) begin
        if (step_q == 4'(MOD_STEPS - 1)) begin
          moding_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
    end
  end

  // Hold the hash word, key bytes, remainder and resulting index
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_start) begin
      h_q        <= (cmd_i.seed_sel == SEED_TWO) ? HASH2_SEED : HASH1_SEED;
      kb_q       <= (cmd_i.key_sel == KSEL_RD1) ? rd1_q.key : ck_q;
      seed_two_q <= (cmd_i.seed_sel == SEED_TWO);
      r_q        <= '0;
    end else if (hashing_q) begin
      h_q  <= h_fold;
      kb_q <= {8'd0, kb_q[31:8]};
    end else if (moding_q) begin
      h_q <= h_tmp;
      r_q <= r_tmp;
      if (step_q == 4'(MOD_STEPS - 1)) begin
        idx_q <= r_tmp[IDX_W-1:0];
      end
    end
  end

  // Hold the carried entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      ck_q   <= key_i & KEY_MASK;
      cv_q   <= SV_W'(value_i);
    end else if (cmd_i.swap) begin
      ck_q <= rd2_q.key;
      cv_q <= rd2_q.val;
    end
  end

  // Table one
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem1[clr_q] <= '0;
    end else if (cmd_i.wr1) begin
      mem1[idx_q] <= '{vld: 1'b1, key: ck_q, val: cv_q};
    end
    if (cmd_i.rd1) begin
      rd1_q <= mem1[idx_q];
    end
  end

  // Table two, fed by the entry pushed out of table one
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem2[clr_q] <= '0;
    end else if (cmd_i.wr2) begin
      mem2[idx_q] <= '{vld: 1'b1, key: rd1_q.key, val: rd1_q.val};
    end
    if (cmd_i.rd2) begin
      rd2_q <= mem2[idx_q];
    end
  end

  // Advance the clearing address and the occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      found_o         <= (cmd_i.res_kind == RES_HIT1) || (cmd_i.res_kind == RES_HIT2);
      entry_total_o   <= 12'(cnt_q);
      dropped_o       <= (cmd_i.res_kind == RES_DROP);
      dropped_key_o   <= (cmd_i.res_kind == RES_DROP) ? ck_q : 32'd0;
      dropped_value_o <= (cmd_i.res_kind == RES_DROP) ? 32'(cv_q) : 32'd0;
      case (cmd_i.res_kind)
        RES_HIT1: read_value_o <= 32'(rd1_q.val);
        RES_HIT2: read_value_o <= 32'(rd2_q.val);
        default:  read_value_o <= 32'd0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.hash_done = done_q;
  assign status_o.clr_last  = (clr_q == IDX_W'(TABLE_DEPTH - 1));
  assign status_o.is_insert = (func_q == FUNC_INSERT);
  assign status_o.v1        = rd1_q.vld;
  assign status_o.eq1       = (rd1_q.key == ck_q);
  assign status_o.v2        = rd2_q.vld;
  assign status_o.eq2ck     = (rd2_q.key == ck_q);
  assign status_o.eq2ok     = (rd2_q.key == rd1_q.key);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ----- hdl/cht_ctrl.sv -----
// Controller of the cuckoo hash table: clearing pass, lookup and
// displacement sequencing. Depends on cht_pkg.
`timescale 1ns / 1ps

module cht_ctrl import cht_pkg::*; #(
  parameter int MAX_KICKS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cht_status_t status_i,
  output cht_cmd_t    cmd_o
);

  localparam int KW = $clog2(MAX_KICKS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_H1, S_R1, S_C1, S_H2, S_R2, S_C2, S_FIN
  } state_e;

  state_e    state_q, state_d;
  logic [KW-1:0] kick_q, kick_d;
  res_kind_e res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o          = '0;
    cmd_o.key_sel  = KSEL_CK;
    cmd_o.seed_sel = SEED_ONE;
    cmd_o.res_kind = res_q;
    state_d        = state_q;
    kick_d         = kick_q;
    res_d          = res_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          kick_d     = '0;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.hash_start = 1'b1;
        state_d          = S_H1;
      end
      S_H1: begin
        if (status_i.hash_done) state_d = S_R1;
      end
      S_R1: begin
        cmd_o.rd1 = 1'b1;
        state_d   = S_C1;
      end
      S_C1: begin
        if (!status_i.is_insert) begin
          if (status_i.v1 && status_i.eq1) begin
            res_d   = RES_HIT1;
            state_d = S_FIN;
          end else begin
            cmd_o.hash_start = 1'b1;
            cmd_o.seed_sel   = SEED_TWO;
            state_d          = S_H2;
          end
        end else begin
          cmd_o.wr1 = 1'b1;
          res_d     = RES_PLAIN;
          if (!status_i.v1) begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = S_FIN;
          end else if (status_i.eq1) begin
            state_d = S_FIN;
          end else begin
            cmd_o.hash_start = 1'b1;
            cmd_o.key_sel    = KSEL_RD1;
            cmd_o.seed_sel   = SEED_TWO;
            state_d          = S_H2;
          end
        end
      end
      S_H2: begin
        if (status_i.hash_done) state_d = S_R2;
      end
      S_R2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = S_C2;
      end
      S_C2: begin
        if (!status_i.is_insert) begin
          res_d   = (status_i.v2 && status_i.eq2ck) ? RES_HIT2 : RES_PLAIN;
          state_d = S_FIN;
        end else begin
          cmd_o.wr2 = 1'b1;
          res_d     = RES_PLAIN;
          if (!status_i.v2) begin
            cmd_o.cnt_inc = 1'b1;
            state_d       = S_FIN;
          end else if (status_i.eq2ok) begin
            state_d = S_FIN;
          end else begin
            // carry table two's evictee into the next round or drop it
            cmd_o.swap = 1'b1;
            if (kick_q == KW'(MAX_KICKS)) begin
              res_d   = RES_DROP;
              state_d = S_FIN;
            end else begin
              kick_d  = kick_q + KW'(1);
              state_d = S_START;
            end
          end
        end
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, kick count and pending result kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kick_q  <= '0;
      res_q   <= RES_PLAIN;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
      res_q   <= res_d;
    end
  end

endmodule

// ----- hdl/cuckoo_hash_table.sv -----
// Top level of the two-way cuckoo hash table.
// Depends on cht_pkg, cht_ctrl and cht_datapath.
`timescale 1ns / 1ps

// Stores keys with values in two tables indexed by two byte-wise hashes.
// After reset the block runs a clearing pass and accepts no item until it
// ends. One item is processed at a time. Each hash index is computed in the
// shared hash and modulo unit (one key byte per cycle, then eight remainder
// bits per cycle over 64 bits), and each table probe adds a read and a
// compare step. A lookup either hits table one or goes on to table two. An
// insert runs displacement rounds, each of which either reaches table two
// or ends in table one, over at most MAX_KICKS + 1 rounds. The result waits
// in an output register; the next item is taken while it waits, and its own
// result is held back until the register is free.
module cuckoo_hash_table import cht_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 4,
  parameter int MAX_KICKS   = 10,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // func[0], key[32:1], value[64:33], zero fill above
  input  logic [71:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // found[0], read_value[32:1], entry_total[44:33], dropped[45],
  // dropped_key[77:46], dropped_value[109:78], zero fill above
  output logic [111:0] m_axis_tdata_o
);

  cht_cmd_t    cmd;
  cht_status_t status;

  logic        found, dropped;
  logic [31:0] read_value, dropped_key, dropped_value;
  logic [11:0] entry_total;

  cht_ctrl #(
    .MAX_KICKS (MAX_KICKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cht_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (s_axis_tdata_i[0]),
    .key_i           (s_axis_tdata_i[32:1]),
    .value_i         (s_axis_tdata_i[64:33]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .found_o         (found),
    .read_value_o    (read_value),
    .entry_total_o   (entry_total),
    .dropped_o       (dropped),
    .dropped_key_o   (dropped_key),
    .dropped_value_o (dropped_value)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {2'b00, dropped_value, dropped_key, dropped,
                           entry_total, read_value, found};

endmodule
